// ----- design/ocms_pkg.sv -----
// ----------------------------------------------------------------------------
// ocms_pkg
// Shared constants and types of the obstacle cost map stamp.
// ----------------------------------------------------------------------------
package ocms_pkg;

  localparam int GRID_SIZE  = 128;
  localparam int GRID_BITS  = $clog2(GRID_SIZE);
  localparam int MAP_DEPTH  = GRID_SIZE * GRID_SIZE;
  localparam int MAP_BITS   = $clog2(MAP_DEPTH);
  localparam int COST_W     = 11;
  localparam int SAFE_W     = 5;
  localparam int LOSS_W     = 10;
  localparam int HALF_W     = 8;   // safe + floor(3*loss/16) <= 222

  // iterative unit widths
  localparam int RAD_W      = 32;  // (dx^2 + dy^2) << 16
  localparam int ROOT_W     = RAD_W / 2;
  localparam int NUM_W      = 18;  // 256000 needs 18 bits
  localparam int DEN_W      = 16;

  localparam logic [COST_W-1:0] COST_CENTER    = 11'd1200;
  localparam logic [NUM_W-1:0]  COST_INNER_NUM = 18'd256000;
  localparam logic [SAFE_W-1:0] SAFE_RESET     = 5'd4;

  localparam int APB_AW = 3;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              start;
    logic [RAD_W-1:0]  rad;
  } sqrt_req_t;

endpackage

// ----- design/ocms_if.sv -----
// ----------------------------------------------------------------------------
// ocms_req_if / ocms_rsp_if
// Valid/ready channels: request words in, cost words out.
// ----------------------------------------------------------------------------
interface ocms_req_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [ocms_pkg::GRID_BITS-1:0]  cell_x;
  logic [ocms_pkg::GRID_BITS-1:0]  cell_y;
  logic [ocms_pkg::LOSS_W-1:0]     loss;
  modport source (output valid, action, cell_x, cell_y, loss, input ready);
  modport sink   (input valid, action, cell_x, cell_y, loss, output ready);
endinterface

interface ocms_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ocms_pkg::COST_W-1:0]  cost;
  modport source (output valid, cost, input ready);
  modport sink   (input valid, cost, output ready);
endinterface

// ----- design/obstacle_cost_map_stamp.sv -----
// ----------------------------------------------------------------------------
// obstacle_cost_map_stamp
// 128x128 obstacle cost map with window stamping and cell reads.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass, one map entry per cycle, and
// takes no request word until it ends (register writes are taken
// throughout). A stamp word walks every in-grid cell of its window,
// half-width safe_distance+floor(3*loss/16), one cell at a time through the
// square root, the divider (for off-center cells inside the radius) and the
// map read-modify-write. Each word gives one cost word (zero for a stamp);
// a finished cost waits in the output register.
// ----------------------------------------------------------------------------
module obstacle_cost_map_stamp (
  input  logic                          clk,
  input  logic                          rst,
  ocms_req_if.sink                      req,
  ocms_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ocms_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ocms_pkg::*;

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDW   = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_CELL  = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_SQW   = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_APPLY = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  localparam logic [GRID_BITS-1:0] GRID_MAX = GRID_BITS'(GRID_SIZE - 1);

  // ---- configuration ----
  logic [SAFE_W-1:0] safe_distance;

  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == 1'b0) ? {{(32-SAFE_W){1'b0}}, safe_distance} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      safe_distance <= SAFE_RESET;
    end else if (psel && penable && pwrite && (paddr[APB_AW-1] == 1'b0)) begin
      safe_distance <= pwdata[SAFE_W-1:0];
    end
  end

  // ---- sequencer registers ----
  logic [3:0]            state;
  logic [MAP_BITS-1:0]   clr_addr;
  logic [GRID_BITS-1:0]  cx, cy;          // stamp center
  logic [LOSS_W-1:0]     loss;
  logic [SAFE_W-1:0]     safe;            // safe_distance latched per stamp
  logic [HALF_W-1:0]     half;
  logic [2*SAFE_W-1:0]   safe_sq;
  logic [2*HALF_W-1:0]   half_sq;
  logic [GRID_BITS-1:0]  i_hi, j_lo, j_hi;
  logic [GRID_BITS-1:0]  ci, cj;          // current cell
  logic [14:0]           d2;              // dx^2 + dy^2
  logic                  band_in;         // inner band of current cell
  logic [COST_W-1:0]     cost_new;
  logic [COST_W-1:0]     res_cost;        // result held until output free
  logic                  out_valid;
  logic [COST_W-1:0]     out_cost;

  // ---- map and arithmetic units ----
  logic                  ram_we, ram_re;
  logic [MAP_BITS-1:0]   ram_waddr, ram_raddr;
  logic [COST_W-1:0]     ram_wdata, ram_rdata;

  sqrt_req_t             sq_req;
  logic                  sq_done;
  logic [ROOT_W-1:0]     dq;
  div_req_t              dv_req;
  logic                  dv_done;
  logic [NUM_W-1:0]      quo;

  ocms_ram #(.WIDTH(COST_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ocms_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sq_req), .done(sq_done), .root(dq));
  ocms_div  u_div  (.clk(clk), .rst(rst), .req(dv_req), .done(dv_done), .quo(quo));

  // ---- combinational helpers ----
  logic signed [9:0]   lo_x, lo_y;
  logic [9:0]          hi_x, hi_y;
  logic [HALF_W-1:0]   half_calc;
  logic [11:0]         loss3;
  logic signed [7:0]   dx, dy;
  logic signed [15:0]  dx_sq, dy_sq;
  logic [DEN_W-1:0]    loss48;
  logic [DEN_W-1:0]    out_den;
  logic [NUM_W:0]      outer_q;
  logic                last_cell;
  logic                out_free;

  assign loss3     = 12'({2'b00, req.loss} + {1'b0, req.loss, 1'b0});
  assign half_calc = HALF_W'({3'b000, safe_distance} + {1'b0, loss3[11:4]});

  assign lo_x = $signed({3'b000, cx}) - $signed({2'b00, half});
  assign lo_y = $signed({3'b000, cy}) - $signed({2'b00, half});
  assign hi_x = {3'b000, cx} + {2'b00, half};
  assign hi_y = {3'b000, cy} + {2'b00, half};

  assign dx    = $signed({1'b0, ci}) - $signed({1'b0, cx});
  assign dy    = $signed({1'b0, cj}) - $signed({1'b0, cy});
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  assign loss48  = DEN_W'({loss, 5'b0}) + DEN_W'({loss, 4'b0});
  assign out_den = dq - DEN_W'({safe, 8'b0});
  assign outer_q = {1'b0, quo} + 1'b1;

  assign last_cell = (ci == i_hi) && (cj == j_hi);
  assign out_free  = !out_valid || rsp.ready;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.cost  = out_cost;

  // map port and unit start drive: clearing pass, read word or read-modify-write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {ci, cj};
    ram_wdata = cost_new;
    ram_re    = 1'b0;
    ram_raddr = {ci, cj};
    sq_req    = '{start: 1'b0, rad: {1'b0, d2, 16'b0}};
    dv_req    = '{start: 1'b0, num: COST_INNER_NUM, den: dq};
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_re    = req.valid && req.action;
        ram_raddr = {req.cell_x, req.cell_y};
      end
      S_CELL: begin
        ram_re = 1'b1;
      end
      S_SQ: begin
        sq_req.start = 1'b1;
      end
      S_SQW: begin
        if (sq_done && (d2 != '0)) begin
          if (d2 <= {5'b0, safe_sq}) begin
            dv_req.start = 1'b1;
          end else if ({1'b0, d2} <= half_sq) begin
            dv_req = '{start: 1'b1, num: {2'b00, loss48}, den: out_den};
          end
        end
      end
      S_APPLY: begin
        ram_we = cost_new > ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == MAP_BITS'(MAP_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cx   <= req.cell_x;
            cy   <= req.cell_y;
            loss <= req.loss;
            safe <= safe_distance;
            half <= half_calc;
            state <= req.action ? S_RDW : S_SETUP;
          end
        end
        S_RDW: begin
          res_cost <= ram_rdata;
          state    <= S_FIN;
        end
        S_SETUP: begin
          // clip window to the grid
          j_lo    <= (lo_y < 0) ? '0 : lo_y[GRID_BITS-1:0];
          i_hi    <= (hi_x > 10'(GRID_SIZE - 1)) ? GRID_MAX : hi_x[GRID_BITS-1:0];
          j_hi    <= (hi_y > 10'(GRID_SIZE - 1)) ? GRID_MAX : hi_y[GRID_BITS-1:0];
          ci      <= (lo_x < 0) ? '0 : lo_x[GRID_BITS-1:0];
          cj      <= (lo_y < 0) ? '0 : lo_y[GRID_BITS-1:0];
          safe_sq <= safe * safe;
          half_sq <= half * half;
          state   <= S_CELL;
        end
        S_CELL: begin
          d2    <= 15'(dx_sq[13:0]) + 15'(dy_sq[13:0]);
          state <= S_SQ;
        end
        S_SQ: begin
          state <= S_SQW;
        end
        S_SQW: begin
          if (sq_done) begin
            band_in <= (d2 <= {5'b0, safe_sq});
            if (d2 == '0) begin
              cost_new <= COST_CENTER;
              state    <= S_APPLY;
            end else if ((d2 <= {5'b0, safe_sq}) || ({1'b0, d2} <= half_sq)) begin
              state <= S_DIVW;
            end else begin
              cost_new <= '0;   // window corner beyond the radius
              state    <= S_APPLY;
            end
          end
        end
        S_DIVW: begin
          if (dv_done) begin
            if (band_in) begin
              cost_new <= quo[COST_W-1:0];
            end else if (outer_q > {8'b0, COST_CENTER}) begin
              cost_new <= COST_CENTER;
            end else if (outer_q == 19'd1) begin
              cost_new <= '0;   // unit cost is dropped
            end else begin
              cost_new <= outer_q[COST_W-1:0];
            end
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (last_cell) begin
            res_cost <= '0;
            state    <= S_FIN;
          end else begin
            if (cj == j_hi) begin
              cj <= j_lo;
              ci <= ci + 1'b1;
            end else begin
              cj <= cj + 1'b1;
            end
            state <= S_CELL;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_cost  <= res_cost;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/ocms_ram.sv -----
// ----------------------------------------------------------------------------
// ocms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ocms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/ocms_sqrt.sv -----
// ----------------------------------------------------------------------------
// ocms_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ocms_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  ocms_pkg::sqrt_req_t         req,
  output logic                        done,
  output logic [ocms_pkg::ROOT_W-1:0] root
);
  import ocms_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fit;

  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fit    = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= req.rad;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        if (fit) begin
          rem  <= REM_W'(rem_sh - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= REM_W'(rem_sh);
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/ocms_div.sv -----
// ----------------------------------------------------------------------------
// ocms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ocms_div (
  input  logic                       clk,
  input  logic                       rst,
  input  ocms_pkg::div_req_t         req,
  output logic                       done,
  output logic [ocms_pkg::NUM_W-1:0] quo
);
  import ocms_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    rem_sh;
  logic              fit;

  assign rem_sh = {rem, num[NUM_W-1]};
  assign fit    = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        num <= {num[NUM_W-2:0], 1'b0};
        if (fit) begin
          rem <= DEN_W'(rem_sh - {1'b0, den});
        end else begin
          rem <= DEN_W'(rem_sh);
        end
        quo <= {quo[NUM_W-2:0], fit};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
